// ===== design/ptrs_pkg.sv =====
// Package for the priority task ready scheduler: request, response and sweep types
// plus operation, status and controller state codes. No dependencies.
package ptrs_pkg;

  localparam int IdW   = 8;
  localparam int PrioW = 8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READY = 2'd2,
    OP_PICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_EMPTY     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_RD,
    S_SCAN,
    S_FIX,
    S_WRITE
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [3:0]       slot;
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] task_priority;
    logic             start_ready;
  } req_t;

  typedef struct packed {
    status_e        status;
    logic [IdW-1:0] granted_id;
    logic [3:0]     granted_slot;
  } rsp_t;

  // sweep engine status toward the controller
  typedef struct packed {
    logic busy;     // sweep in progress
    logic tap_vld;  // read data for the tap index is valid this cycle
    logic done;     // last entry handled, sweep ends this cycle
  } sweep_st_t;

endpackage

// ===== design/ptrs_mem.sv =====
// Slot memory of the priority task ready scheduler: one write port, one read port,
// read data registered. No package dependencies.
module ptrs_mem #(
  parameter int Depth = 16,
  parameter int Width = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ptrs_sweep.sv =====
// Sweep engine of the priority task ready scheduler: walks every slot address once
// and tracks which slot the registered read data belongs to. Uses ptrs_pkg.
module ptrs_sweep #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  output logic [$clog2(MAX_TASKS)-1:0] rd_addr_o,
  output logic [$clog2(MAX_TASKS)-1:0] tap_idx_o,
  output ptrs_pkg::sweep_st_t          st_o
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic          active_q, active_d;
  logic          vld_q, vld_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          issue;
  logic          done;

  assign issue = active_q && (cnt_q != CW'(MAX_TASKS));
  assign done  = active_q && !issue && !vld_q;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    vld_d    = issue;
    idx_d    = cnt_q[AW-1:0];
    if (go_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      vld_d    = 1'b0;
    end else begin
      if (issue) begin
        cnt_d = cnt_q + CW'(1);
      end
      if (done) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      vld_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      vld_q    <= vld_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign rd_addr_o    = cnt_q[AW-1:0];
  assign tap_idx_o    = idx_q;
  assign st_o.busy    = active_q;
  assign st_o.tap_vld = vld_q;
  assign st_o.done    = done;

endmodule

// ===== design/priority_task_ready_scheduler_unit.sv =====
// Top level of the priority task ready scheduler: controller, slot flags and counters.
// Depends on ptrs_pkg, ptrs_mem and ptrs_sweep.
//
// Fixed-priority task scheduler with first-come order among equal priorities. A request
// is taken when start is high and busy is low; busy stays high until the result has been
// written to rsp_o, which is shown for exactly one cycle with rsp_valid_o high. The
// receiver cannot stall the block, so rsp_o must be captured in that cycle. Task id,
// priority and arrival rank of every slot live in one slot memory with a single read port
// and registered read data; used and ready marks are flip-flops cleared by reset.
// Every walk over the slots (search, or rank repair after a task leaves the ready set)
// reads one slot per cycle. Clear and loads of a slot at or above MAX_TASKS answer
// straight from idle; a load of a slot that is not ready writes the entry; a load of a
// ready slot reads the old rank, repairs ranks and then writes; make-ready searches and
// then writes, or answers when no match is found; a pick searches and, when a task is
// granted, repairs ranks before answering. The next request can follow as soon as
// busy falls, which happens in the cycle the result appears.
module priority_task_ready_scheduler_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ptrs_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output ptrs_pkg::rsp_t rsp_o
);

  localparam int AW  = $clog2(MAX_TASKS);        // slot index width
  localparam int RkW = AW;                       // arrival rank width
  localparam int CW  = $clog2(MAX_TASKS + 1);    // ready count width
  localparam int IdW = ptrs_pkg::IdW;
  localparam int PrW = ptrs_pkg::PrioW;
  localparam int EW  = IdW + PrW + RkW;          // memory entry: {id, prio, rank}

  // controller state
  ptrs_pkg::state_e state_q, state_d;
  ptrs_pkg::req_t   req_q, req_d;

  // per-slot flags, cleared by reset
  logic [MAX_TASKS-1:0] used_q, used_d;
  logic [MAX_TASKS-1:0] ready_q, ready_d;
  logic [CW-1:0]        count_q, count_d;

  // target slot: search winner, or slot being loaded
  logic            found_q, found_d;
  logic [AW-1:0]   tgt_slot_q, tgt_slot_d;
  logic [IdW-1:0]  tgt_id_q, tgt_id_d;
  logic [PrW-1:0]  tgt_prio_q, tgt_prio_d;
  logic [RkW-1:0]  tgt_rank_q, tgt_rank_d;

  // result register
  logic           rsp_valid_q, rsp_valid_d;
  ptrs_pkg::rsp_t rsp_q, rsp_d;

  // memory and sweep hookup
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [EW-1:0]       mem_rdata;
  logic                sweep_go;
  logic [AW-1:0]       sweep_addr;
  logic [AW-1:0]       tap;
  ptrs_pkg::sweep_st_t sw_st;

  logic [IdW-1:0] rd_id;
  logic [PrW-1:0] rd_prio;
  logic [RkW-1:0] rd_rank;
  logic [AW-1:0]  in_slot;
  logic           in_range;
  logic           tap_live;

  assign rd_id    = mem_rdata[EW-1 -: IdW];
  assign rd_prio  = mem_rdata[RkW +: PrW];
  assign rd_rank  = mem_rdata[RkW-1:0];
  assign in_slot  = AW'(req_i.slot);
  assign in_range = 32'(req_i.slot) < MAX_TASKS;
  assign tap_live = sw_st.tap_vld && used_q[tap] && ready_q[tap];

  // while idle the read port looks at the requested slot, so a load of a ready slot
  // finds its rank in the next cycle; during a sweep the sweep engine owns it
  assign mem_raddr = sw_st.busy ? sweep_addr : in_slot;

  ptrs_mem #(
    .Depth (MAX_TASKS),
    .Width (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ptrs_sweep #(
    .MAX_TASKS (MAX_TASKS)
  ) u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (sweep_go),
    .rd_addr_o (sweep_addr),
    .tap_idx_o (tap),
    .st_o      (sw_st)
  );

  // next state, flag updates and memory write-back
  // a sweep writes back the slot whose read data it holds while reading the next one,
  // and every other write happens with no read in flight, so accesses never overlap
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    used_d      = used_q;
    ready_d     = ready_q;
    count_d     = count_q;
    found_d     = found_q;
    tgt_slot_d  = tgt_slot_q;
    tgt_id_d    = tgt_id_q;
    tgt_prio_d  = tgt_prio_q;
    tgt_rank_d  = tgt_rank_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    sweep_go    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = tgt_slot_q;
    mem_wdata   = {tgt_id_q, tgt_prio_q, count_q[RkW-1:0]};

    unique case (state_q)
      ptrs_pkg::S_IDLE: begin
        if (start) begin
          req_d = req_i;
          unique case (req_i.op)
            ptrs_pkg::OP_CLEAR: begin
              used_d             = '0;
              ready_d            = '0;
              count_d            = '0;
              rsp_valid_d        = 1'b1;
              rsp_d.status       = ptrs_pkg::STS_OK;
              rsp_d.granted_id   = '0;
              rsp_d.granted_slot = '0;
            end
            ptrs_pkg::OP_LOAD: begin
              if (!in_range) begin
                // slot beyond the table: ignored
                rsp_valid_d        = 1'b1;
                rsp_d.status       = ptrs_pkg::STS_OK;
                rsp_d.granted_id   = '0;
                rsp_d.granted_slot = '0;
              end else begin
                tgt_slot_d = in_slot;
                tgt_id_d   = req_i.task_id;
                tgt_prio_d = req_i.task_priority;
                if (used_q[in_slot] && ready_q[in_slot]) begin
                  state_d = ptrs_pkg::S_LOAD_RD;  // old task must leave the ready set
                end else begin
                  state_d = ptrs_pkg::S_WRITE;
                end
              end
            end
            ptrs_pkg::OP_READY, ptrs_pkg::OP_PICK: begin
              found_d  = 1'b0;
              sweep_go = 1'b1;
              state_d  = ptrs_pkg::S_SCAN;
            end
            default: begin
              state_d = ptrs_pkg::S_IDLE;
            end
          endcase
        end
      end

      ptrs_pkg::S_LOAD_RD: begin
        // rank of the old task is on the read port now
        tgt_rank_d          = rd_rank;
        ready_d[tgt_slot_q] = 1'b0;
        count_d             = count_q - CW'(1);
        sweep_go            = 1'b1;
        state_d             = ptrs_pkg::S_FIX;
      end

      ptrs_pkg::S_SCAN: begin
        if (req_q.op == ptrs_pkg::OP_PICK) begin
          // most urgent priority, then oldest arrival
          if (tap_live && (!found_q || rd_prio < tgt_prio_q ||
                           (rd_prio == tgt_prio_q && rd_rank < tgt_rank_q))) begin
            found_d    = 1'b1;
            tgt_slot_d = tap;
            tgt_id_d   = rd_id;
            tgt_prio_d = rd_prio;
            tgt_rank_d = rd_rank;
          end
        end else begin
          // lowest used, blocked slot with a matching id
          if (sw_st.tap_vld && used_q[tap] && !ready_q[tap] &&
              rd_id == req_q.task_id && !found_q) begin
            found_d    = 1'b1;
            tgt_slot_d = tap;
            tgt_id_d   = rd_id;
            tgt_prio_d = rd_prio;
          end
        end
        if (sw_st.done) begin
          if (req_q.op == ptrs_pkg::OP_PICK) begin
            if (found_q) begin
              ready_d[tgt_slot_q] = 1'b0;
              count_d             = count_q - CW'(1);
              sweep_go            = 1'b1;
              state_d             = ptrs_pkg::S_FIX;
            end else begin
              rsp_valid_d        = 1'b1;
              rsp_d.status       = ptrs_pkg::STS_EMPTY;
              rsp_d.granted_id   = '0;
              rsp_d.granted_slot = '0;
              state_d            = ptrs_pkg::S_IDLE;
            end
          end else begin
            if (found_q) begin
              state_d = ptrs_pkg::S_WRITE;
            end else begin
              rsp_valid_d        = 1'b1;
              rsp_d.status       = ptrs_pkg::STS_NOT_FOUND;
              rsp_d.granted_id   = '0;
              rsp_d.granted_slot = '0;
              state_d            = ptrs_pkg::S_IDLE;
            end
          end
        end
      end

      ptrs_pkg::S_FIX: begin
        // close the rank gap left by the departing task
        if (tap_live && rd_rank > tgt_rank_q) begin
          mem_we    = 1'b1;
          mem_waddr = tap;
          mem_wdata = {rd_id, rd_prio, rd_rank - RkW'(1)};
        end
        if (sw_st.done) begin
          if (req_q.op == ptrs_pkg::OP_PICK) begin
            rsp_valid_d        = 1'b1;
            rsp_d.status       = ptrs_pkg::STS_OK;
            rsp_d.granted_id   = tgt_id_q;
            rsp_d.granted_slot = 4'(tgt_slot_q);
            state_d            = ptrs_pkg::S_IDLE;
          end else begin
            state_d = ptrs_pkg::S_WRITE;
          end
        end
      end

      ptrs_pkg::S_WRITE: begin
        // store entry; a task entering the ready set takes the back rank
        mem_we             = 1'b1;
        used_d[tgt_slot_q] = 1'b1;
        if (req_q.op == ptrs_pkg::OP_READY || req_q.start_ready) begin
          ready_d[tgt_slot_q] = 1'b1;
          count_d             = count_q + CW'(1);
        end
        rsp_valid_d        = 1'b1;
        rsp_d.status       = ptrs_pkg::STS_OK;
        rsp_d.granted_id   = '0;
        rsp_d.granted_slot = '0;
        state_d            = ptrs_pkg::S_IDLE;
      end

      default: begin
        state_d = ptrs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptrs_pkg::S_IDLE;
      used_q      <= '0;
      ready_q     <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ready_q     <= ready_d;
      count_q     <= count_d;
      found_q     <= found_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    tgt_slot_q <= tgt_slot_d;
    tgt_id_q   <= tgt_id_d;
    tgt_prio_q <= tgt_prio_d;
    tgt_rank_q <= tgt_rank_d;
    rsp_q      <= rsp_d;
  end

  assign busy        = (state_q != ptrs_pkg::S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // a result only appears while the controller is idle
  a_rsp_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (state_q == ptrs_pkg::S_IDLE))
    else $error("result strobe while controller busy");

  // only used slots can be ready
  a_ready_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_q & ~used_q) == '0)
    else $error("ready mark on unused slot");

  // between requests the ready count matches the ready marks
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptrs_pkg::S_IDLE) |-> (32'(count_q) == $countones(ready_q)))
    else $error("ready count out of step with ready marks");

  // only a successful pick carries a grant
  a_grant_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ptrs_pkg::STS_OK) |->
      (rsp_o.granted_id == '0 && rsp_o.granted_slot == '0))
    else $error("grant fields set on failed request");

endmodule
